// ===== rtl/forwarding_table_exact_match_macros.svh =====
// Assertion macros shared by the checker of the forwarding table.
// Each macro expects clk and rst to be visible where it is used.
`ifndef FORWARDING_TABLE_EXACT_MATCH_MACROS_SVH
`define FORWARDING_TABLE_EXACT_MATCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTEM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// The consequent must hold in the cycle after the antecedent.
`define FTEM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== rtl/ftem_pkg.sv =====
// Package of the exact-match forwarding table: field widths, codes and the
// structures passed along the row of cells. No dependencies.
package ftem_pkg;

  localparam int ADDR_W      = 16;
  localparam int PORT_W      = 8;
  localparam int DELAY_W     = 16;
  localparam int STATUS_W    = 3;
  localparam int LIMIT_W     = 5;
  localparam int COUNT_OUT_W = 5;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  localparam int TABLE_SIZE_DEF = 16;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MATCHED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DEFAULT   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOROUTE   = 3'd5;

  localparam logic [1:0] REG_TABLE_LIMIT   = 2'd0;
  localparam logic [1:0] REG_DEFAULT_VALID = 2'd1;
  localparam logic [1:0] REG_DEFAULT_PORT  = 2'd2;
  localparam logic [1:0] REG_DEFAULT_DELAY = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic               hit;
    logic [PORT_W-1:0]  port;
    logic [DELAY_W-1:0] delay;
  } cell_tok_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  address;
    logic [PORT_W-1:0]  port;
    logic [DELAY_W-1:0] delay;
  } cell_wr_t;

endpackage

// ===== rtl/ftem_cell.sv =====
// One cell of the forwarding table: holds a single entry, compares it with
// the passing query and hands the query on. Depends on ftem_pkg.
module ftem_cell #(
  parameter int CNT_W = $clog2(ftem_pkg::TABLE_SIZE_DEF + 1),
  parameter int INDEX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  ftem_pkg::cell_tok_t in_tok,
  output logic                out_valid,
  output ftem_pkg::cell_tok_t out_tok,
  input  logic [CNT_W-1:0]    count,
  input  ftem_pkg::cell_wr_t  wr
);
  import ftem_pkg::*;

  logic [ADDR_W-1:0]  entry_address;
  logic [PORT_W-1:0]  entry_port;
  logic [DELAY_W-1:0] entry_delay;
  logic               live;
  logic               match;

  assign live  = count > CNT_W'(INDEX);
  assign match = live && !in_tok.hit && (entry_address == in_tok.address);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_tok.address <= in_tok.address;
    out_tok.hit     <= in_tok.hit | match;
    out_tok.port    <= match ? entry_port : in_tok.port;
    out_tok.delay   <= match ? entry_delay : in_tok.delay;
  end

  always_ff @(posedge clk) begin
    if (wr.en && (count == CNT_W'(INDEX))) begin
      entry_address <= wr.address;
      entry_port    <= wr.port;
      entry_delay   <= wr.delay;
    end
  end

endmodule

// ===== rtl/forwarding_table_exact_match.sv =====
// Exact-match forwarding table with a default route. Entries live in a row of
// TABLE_SIZE cells; a query enters the first cell when it is accepted and moves
// one cell per cycle, each cell holding one entry and recording the first hit.
// An item passes from the last cell through the internal holding register to
// the output register, and a new item is taken only once the previous result
// has left the holding register, so the table works on one item at a time.
// Inserts append at the entry count, failing as full at the limit (capped at
// TABLE_SIZE) or as duplicate when the address is already held; lookups
// return the first match, then the default route when set. Registers at byte
// addresses 0, 4, 8 and 12: table limit, default valid, default port and
// default delay. Depends on ftem_pkg and ftem_cell.
module forwarding_table_exact_match #(
  parameter int TABLE_SIZE = ftem_pkg::TABLE_SIZE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                action,
  input  logic [ftem_pkg::ADDR_W-1:0]         address,
  input  logic [ftem_pkg::PORT_W-1:0]         port,
  input  logic [ftem_pkg::DELAY_W-1:0]        delay,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ftem_pkg::STATUS_W-1:0]       status,
  output logic [ftem_pkg::PORT_W-1:0]         hop_port,
  output logic [ftem_pkg::DELAY_W-1:0]        hop_delay,
  output logic [ftem_pkg::COUNT_OUT_W-1:0]    entry_count,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ftem_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [ftem_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [ftem_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);
  import ftem_pkg::*;

  localparam int CNT_W = $clog2(TABLE_SIZE + 1);
  localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  logic [LIMIT_W-1:0] table_limit;
  logic               default_valid;
  logic [PORT_W-1:0]  default_port;
  logic [DELAY_W-1:0] default_delay;
  logic               cfg_wr;
  logic [1:0]         cfg_index;

  cell_tok_t          tok [TABLE_SIZE+1];
  logic [TABLE_SIZE:0] tok_valid;
  cell_tok_t          end_tok;
  cell_wr_t           wr_ctl;

  logic               accept;
  logic               in_flight;
  logic               item_action;
  logic [PORT_W-1:0]  item_port;
  logic [DELAY_W-1:0] item_delay;
  logic [CNT_W-1:0]   entry_total;
  logic [CNT_W-1:0]   count_next;
  logic [LIM_W-1:0]   limit_ext;
  logic [LIM_W-1:0]   limit_eff;
  logic [LIM_W-1:0]   count_ext;
  logic [LIM_W-1:0]   count_next_ext;
  logic               full;
  logic               do_insert;

  logic [STATUS_W-1:0]    res_status;
  logic [PORT_W-1:0]      res_port;
  logic [DELAY_W-1:0]     res_delay;

  logic                   pend_valid;
  logic [STATUS_W-1:0]    pend_status;
  logic [PORT_W-1:0]      pend_port;
  logic [DELAY_W-1:0]     pend_delay;
  logic [COUNT_OUT_W-1:0] pend_count;
  logic                   out_free;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite & pready;
  assign cfg_index = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      table_limit   <= LIMIT_RESET;
      default_valid <= 1'b0;
      default_port  <= '0;
      default_delay <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_TABLE_LIMIT:   table_limit   <= pwdata[LIMIT_W-1:0];
        REG_DEFAULT_VALID: default_valid <= pwdata[0];
        REG_DEFAULT_PORT:  default_port  <= pwdata[PORT_W-1:0];
        REG_DEFAULT_DELAY: default_delay <= pwdata[DELAY_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      REG_TABLE_LIMIT:   prdata = CFG_DATA_W'(table_limit);
      REG_DEFAULT_VALID: prdata = CFG_DATA_W'(default_valid);
      REG_DEFAULT_PORT:  prdata = CFG_DATA_W'(default_port);
      REG_DEFAULT_DELAY: prdata = CFG_DATA_W'(default_delay);
    endcase
  end

  // Input side and the row of cells.
  assign in_stall = rst | in_flight | pend_valid;
  assign accept   = in_valid & ~in_stall;

  assign tok_valid[0]   = accept;
  assign tok[0].address = address;
  assign tok[0].hit     = 1'b0;
  assign tok[0].port    = '0;
  assign tok[0].delay   = '0;

  for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_cell
    ftem_cell #(
      .CNT_W (CNT_W),
      .INDEX (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (tok_valid[g]),
      .in_tok    (tok[g]),
      .out_valid (tok_valid[g+1]),
      .out_tok   (tok[g+1]),
      .count     (entry_total),
      .wr        (wr_ctl)
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= 1'b0;
    end else if (accept) begin
      in_flight <= 1'b1;
    end else if (tok_valid[TABLE_SIZE]) begin
      in_flight <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_action <= action;
      item_port   <= port;
      item_delay  <= delay;
    end
  end

  // Decision once the query has left the last cell.
  assign end_tok   = tok[TABLE_SIZE];
  assign limit_ext = LIM_W'(table_limit);
  assign limit_eff = (limit_ext > LIM_W'(TABLE_SIZE)) ? LIM_W'(TABLE_SIZE) : limit_ext;
  assign count_ext = LIM_W'(entry_total);
  assign full      = count_ext >= limit_eff;

  always_comb begin
    res_status = ST_NOROUTE;
    res_port   = '0;
    res_delay  = '0;
    do_insert  = 1'b0;
    if (item_action == ACT_INSERT) begin
      priority if (full) begin
        res_status = ST_FULL;
      end else if (end_tok.hit) begin
        res_status = ST_DUPLICATE;
      end else begin
        res_status = ST_INSERTED;
        do_insert  = 1'b1;
      end
    end else begin
      priority if (end_tok.hit) begin
        res_status = ST_MATCHED;
        res_port   = end_tok.port;
        res_delay  = end_tok.delay;
      end else if (default_valid) begin
        res_status = ST_DEFAULT;
        res_port   = default_port;
        res_delay  = default_delay;
      end else begin
        res_status = ST_NOROUTE;
      end
    end
  end

  assign count_next     = do_insert ? CNT_W'(entry_total + CNT_W'(1)) : entry_total;
  assign count_next_ext = LIM_W'(count_next);

  assign wr_ctl.en      = tok_valid[TABLE_SIZE] & do_insert;
  assign wr_ctl.address = end_tok.address;
  assign wr_ctl.port    = item_port;
  assign wr_ctl.delay   = item_delay;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_total <= '0;
    end else if (wr_ctl.en) begin
      entry_total <= count_next;
    end
  end

  // Holding register, then the output register.
  assign out_free = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (tok_valid[TABLE_SIZE]) begin
      pend_valid <= 1'b1;
    end else if (out_free) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_valid[TABLE_SIZE]) begin
      pend_status <= res_status;
      pend_port   <= res_port;
      pend_delay  <= res_delay;
      pend_count  <= count_next_ext[COUNT_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pend_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pend_valid) begin
      status      <= pend_status;
      hop_port    <= pend_port;
      hop_delay   <= pend_delay;
      entry_count <= pend_count;
    end
  end

endmodule

// ===== rtl/ftem_checker.sv =====
// Port-level checks for the forwarding table, bound to the top level.
// Depends on ftem_pkg and forwarding_table_exact_match_macros.svh.
`include "forwarding_table_exact_match_macros.svh"

module ftem_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [ftem_pkg::STATUS_W-1:0] status,
  input logic [ftem_pkg::PORT_W-1:0]   hop_port,
  input logic [ftem_pkg::DELAY_W-1:0]  hop_delay
);
  import ftem_pkg::*;

  `FTEM_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid)
  `FTEM_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(status) && $stable(hop_port) && $stable(hop_delay))
  `FTEM_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall)
  `FTEM_ASSERT_NOW(a_no_hop_without_route, out_valid && (status == ST_INSERTED || status == ST_FULL || status == ST_DUPLICATE || status == ST_NOROUTE), hop_port == '0 && hop_delay == '0)

endmodule

bind forwarding_table_exact_match ftem_checker u_ftem_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .hop_port  (hop_port),
  .hop_delay (hop_delay)
);
